@@ src/pss_pkg.sv @@
// Package with the shared types, constants and helpers of the pen stroke smoother.
package pss_pkg;

  // Field widths and fixed-point formats.
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned WID_W       = 11;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned CURVE_STEPS = 10;
  localparam int unsigned MAX_OUT     = 20;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned STORE_MAX   = 5;

  // Shared divider of the back part.
  localparam int unsigned DIV_W = COORD_W + WID_W;
  localparam int unsigned DVS_W = WID_W;

  localparam int unsigned STEP_W   = $clog2(CURVE_STEPS + 1);
  localparam int unsigned OUTCNT_W = $clog2(MAX_OUT + 1);

  // Width constants in Q1.10; the step limits are in Q0.8.
  localparam logic [WID_W-1:0] W_ONE      = 11'd1024;
  localparam logic [WID_W-1:0] W_ROOT     = 11'd410;
  localparam logic [WID_W-1:0] W_LIFT     = 11'd102;
  localparam logic [WID_W-1:0] W_FLOOR    = 11'd51;
  localparam logic [7:0]       STEP_EARLY = 8'd205;
  localparam logic [7:0]       STEP_LATE  = 8'd51;

  // Input selector codes.
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_PEN_UP = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_QUANT  = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [PIX_W-1:0]  pen_x;
    logic [PIX_W-1:0]  pen_y;
    logic [TIME_W-1:0] time_ms;
  } pss_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [WID_W-1:0]   out_width;
    logic               last_of_run;
  } pss_out_t;

  typedef struct packed {
    logic [15:0]      min_interval_ms;
    logic [7:0]       min_distance_px;
    logic [15:0]      speed_cap;
    logic [WID_W-1:0] width_quantum;
  } pss_cfg_t;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_ROOT,
    JOB_DIFF,
    JOB_CURVE
  } pss_job_e;

  // One job for the back part. For a curve, tx/ty is the end point.
  typedef struct packed {
    pss_job_e           kind;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [WID_W-1:0]   tw;
  } pss_job_t;

  // Status of the back part seen by the front part.
  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] stored_count;
  } pss_bstat_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_CLASS,
    F_SQ1,
    F_SQ2,
    F_CHECK,
    F_SQRT,
    F_MUL,
    F_DIV,
    F_WIDTH
  } pss_fstate_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_BEZ_ACC,
    B_BEZ_DIV,
    B_WL_MUL,
    B_WL_DIV,
    B_D_START,
    B_D_NDIV,
    B_L_MUL,
    B_L_DIV,
    B_EMIT,
    B_FLUSH
  } pss_bstate_e;

  typedef enum logic [1:0] {
    RET_FIN,
    RET_SUB,
    RET_DIFF
  } pss_ret_e;

  // Saturate a wide coordinate to the output range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic [47:0] v);
    logic [COORD_W-1:0] r;
    if (v > 48'({COORD_W{1'b1}})) begin
      r = '1;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/pss_fifo.sv @@
// Two-entry job queue between the front and back parts.
module pss_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pss_pkg::pss_job_t job_i,
  input  logic              pop_i,
  output logic              empty_o,
  output pss_pkg::pss_job_t job_o
);
  import pss_pkg::*;

  pss_job_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       full;
  logic       do_push, do_pop;

  assign full    = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

@@ src/pss_front.sv @@
// Front part: accepts requests, filters samples and computes the new ink width.
module pss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pss_pkg::pss_in_t    in_data_i,
  input  pss_pkg::pss_cfg_t   cfg_i,
  input  pss_pkg::pss_bstat_t bstat_i,
  input  logic                fifo_empty_i,
  output logic                push_o,
  output pss_pkg::pss_job_t   job_o
);
  import pss_pkg::*;

  localparam int unsigned D8_W  = 25;
  localparam int unsigned SQ_W  = 33;
  localparam int unsigned SV_W  = 49;
  localparam int unsigned DD_W  = D8_W + 10;
  localparam int unsigned DVS_F = 48;

  pss_fstate_e         state_q, state_d;
  pss_in_t             item_q, item_d;
  logic [PIX_W-1:0]    prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [TIME_W-1:0]   prev_t_q, prev_t_d;
  logic [WID_W-1:0]    prev_w_q, prev_w_d;
  logic [TIME_W-1:0]   dt_q, dt_d;
  logic [PIX_W-1:0]    dx_q, dx_d, dy_q, dy_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic [SV_W-1:0]     sv_q, sv_d, sr_q, sr_d, sbit_q, sbit_d;
  logic [D8_W-1:0]     d8_q, d8_d;
  logic [DVS_F-1:0]    dvs_q, dvs_d;
  logic [DVS_F-1:0]    rem_q, rem_d;
  logic [DD_W-1:0]     quo_q, quo_d;
  logic [5:0]          dcnt_q, dcnt_d;

  logic                accept;
  logic [SV_W-1:0]     s_trial;
  logic [DVS_F:0]      d_trial;
  logic                d_ge;
  logic [15:0]         cap_eff;
  logic [WID_W-1:0]    ratio, w0, w1, w2;
  logic [D8_W+7:0]     lim_full;
  logic [D8_W-1:0]     lim;
  logic [WID_W:0]      avg_sum;
  logic [WID_W-1:0]    w_new;
  logic [7:0]          step;
  logic [COORD_W-1:0]  px_q, py_q, mx, my, ex, ey;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = !(state_q == F_IDLE && bstat_i.idle && fifo_empty_i);

  // Shared arithmetic of the iterative steps.
  assign s_trial = sr_q + sbit_q;
  assign d_trial = {rem_q, quo_q[DD_W-1]};
  assign d_ge    = d_trial >= {1'b0, dvs_q};
  assign cap_eff = (cfg_i.speed_cap == 16'd0) ? 16'd1 : cfg_i.speed_cap;

  // Coordinates of the targets built from the sample history.
  assign px_q = sat_coord(48'(item_q.pen_x) << FRAC_BITS);
  assign py_q = sat_coord(48'(item_q.pen_y) << FRAC_BITS);
  assign mx   = sat_coord(((48'(prev_x_q) + 48'(item_q.pen_x) + 48'd1) << FRAC_BITS) >> 1);
  assign my   = sat_coord(((48'(prev_y_q) + 48'(item_q.pen_y) + 48'd1) << FRAC_BITS) >> 1);
  assign ex   = COORD_W'(((48'(prev_x_q) + 48'(item_q.pen_x)) << FRAC_BITS) >> 1);
  assign ey   = COORD_W'(((48'(prev_y_q) + 48'(item_q.pen_y)) << FRAC_BITS) >> 1);

  // Width from the speed ratio, limited in change and averaged.
  always_comb begin
    ratio = (quo_q > DD_W'(W_ONE)) ? W_ONE : quo_q[WID_W-1:0];
    w0    = W_ONE - ratio;
    w1    = (w0 < W_FLOOR) ? W_FLOOR : w0;
    step  = (bstat_i.stored_count > CNT_W'(STORE_MAX - 1)) ? STEP_LATE : STEP_EARLY;
    lim_full = (D8_W+8)'(d8_q) * (D8_W+8)'(step);
    lim   = lim_full[D8_W+7:8];
    w2    = w1;
    if (w1 > prev_w_q && D8_W'(w1 - prev_w_q) > lim) begin
      w2 = prev_w_q + lim[WID_W-1:0];
    end else if (w1 < prev_w_q && D8_W'(prev_w_q - w1) > lim) begin
      w2 = prev_w_q - lim[WID_W-1:0];
    end
    avg_sum = (WID_W+1)'(w2) + (WID_W+1)'(prev_w_q);
    w_new   = avg_sum[WID_W:1];
  end

  // Next state and job generation.
  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    prev_t_d = prev_t_q;
    prev_w_d = prev_w_q;
    dt_d     = dt_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    sq_d     = sq_q;
    sv_d     = sv_q;
    sr_d     = sr_q;
    sbit_d   = sbit_q;
    d8_d     = d8_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;
    push_o   = 1'b0;
    job_o    = '{kind: JOB_CLEAR, tx: px_q, ty: py_q, cx: '0, cy: '0, tw: W_LIFT};

    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          item_d  = in_data_i;
          state_d = F_CLASS;
        end
      end
      F_CLASS: begin
        state_d = F_IDLE;
        dt_d = item_q.time_ms - prev_t_q;
        dx_d = (item_q.pen_x >= prev_x_q) ? item_q.pen_x - prev_x_q : prev_x_q - item_q.pen_x;
        dy_d = (item_q.pen_y >= prev_y_q) ? item_q.pen_y - prev_y_q : prev_y_q - item_q.pen_y;
        priority if (item_q.func == FUNC_START) begin
          push_o   = 1'b1;
          prev_x_d = '0;
          prev_y_d = '0;
          prev_t_d = '0;
          prev_w_d = '0;
        end else if (item_q.func == FUNC_RSVD) begin
          state_d = F_IDLE;
        end else if (item_q.func == FUNC_PEN_UP) begin
          if (bstat_i.stored_count != '0) begin
            push_o     = 1'b1;
            job_o.kind = JOB_DIFF;
          end
        end else if (bstat_i.stored_count == '0) begin
          push_o     = 1'b1;
          job_o.kind = JOB_ROOT;
          job_o.tw   = W_ROOT;
          prev_x_d   = item_q.pen_x;
          prev_y_d   = item_q.pen_y;
          prev_t_d   = item_q.time_ms;
          prev_w_d   = W_ROOT;
        end else begin
          state_d = F_SQ1;
        end
      end
      F_SQ1: begin
        sq_d    = SQ_W'(32'(dx_q) * 32'(dx_q));
        state_d = F_SQ2;
      end
      F_SQ2: begin
        sq_d    = sq_q + SQ_W'(32'(dy_q) * 32'(dy_q));
        state_d = F_CHECK;
      end
      F_CHECK: begin
        if (dt_q < TIME_W'(cfg_i.min_interval_ms) ||
            sq_q < SQ_W'(16'(cfg_i.min_distance_px) * 16'(cfg_i.min_distance_px))) begin
          state_d = F_IDLE;
        end else begin
          sv_d    = SV_W'(sq_q) << 16;
          sr_d    = '0;
          sbit_d  = SV_W'(1) << (SV_W - 1);
          state_d = F_SQRT;
        end
      end
      F_SQRT: begin
        // One result bit of the integer square root per cycle.
        if (sv_q >= s_trial) begin
          sv_d = sv_q - s_trial;
          sr_d = (sr_q >> 1) + sbit_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        if (sbit_q == SV_W'(1)) state_d = F_MUL;
      end
      F_MUL: begin
        d8_d  = sr_q[D8_W-1:0];
        dvs_d = DVS_F'(dt_q) * DVS_F'(cap_eff);
        rem_d = '0;
        if (dt_q == '0) begin
          quo_d   = (sr_q[D8_W-1:0] != '0) ? DD_W'(W_ONE) : '0;
          state_d = F_WIDTH;
        end else begin
          quo_d   = {sr_q[D8_W-1:0], 10'd0};
          dcnt_d  = 6'(DD_W - 1);
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_d = d_ge ? DVS_F'(d_trial - {1'b0, dvs_q}) : DVS_F'(d_trial);
        quo_d = {quo_q[DD_W-2:0], d_ge};
        dcnt_d = dcnt_q - 6'd1;
        if (dcnt_q == '0) state_d = F_WIDTH;
      end
      F_WIDTH: begin
        push_o = 1'b1;
        job_o.tw = w_new;
        if (bstat_i.stored_count == CNT_W'(1)) begin
          job_o.kind = JOB_DIFF;
          job_o.tx   = mx;
          job_o.ty   = my;
        end else begin
          job_o.kind = JOB_CURVE;
          job_o.tx   = ex;
          job_o.ty   = ey;
          job_o.cx   = COORD_W'(32'(prev_x_q) << FRAC_BITS);
          job_o.cy   = COORD_W'(32'(prev_y_q) << FRAC_BITS);
        end
        prev_x_d = item_q.pen_x;
        prev_y_d = item_q.pen_y;
        prev_t_d = item_q.time_ms;
        prev_w_d = w_new;
        state_d  = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Control state and sample history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_t_q <= '0;
      prev_w_q <= '0;
      dcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      prev_t_q <= prev_t_d;
      prev_w_q <= prev_w_d;
      dcnt_q   <= dcnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    dt_q   <= dt_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sq_q   <= sq_d;
    sv_q   <= sv_d;
    sr_q   <= sr_d;
    sbit_q <= sbit_d;
    d8_q   <= d8_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

endmodule

@@ src/pss_div.sv @@
// Iterative restoring divider shared by the back part, one quotient bit per cycle.
module pss_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pss_pkg::DIV_W-1:0]  dividend_i,
  input  logic [pss_pkg::DVS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [pss_pkg::DIV_W-1:0]  quotient_o
);
  import pss_pkg::*;

  localparam int unsigned CW = $clog2(DIV_W);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial      = {rem_q, quo_q[DIV_W-1]};
  assign ge         = trial >= {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

endmodule

@@ src/pss_back.sv @@
// Back part: walks the curve, subdivides by width and delivers stroke points.
module pss_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pss_pkg::pss_cfg_t   cfg_i,
  input  logic                empty_i,
  input  pss_pkg::pss_job_t   job_i,
  output logic                pop_o,
  output pss_pkg::pss_bstat_t bstat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pss_pkg::pss_out_t   out_data_o
);
  import pss_pkg::*;

  localparam int unsigned S2 = CURVE_STEPS * CURVE_STEPS;
  localparam int unsigned CW = $clog2(S2 + 1);
  localparam logic [1:0] LOP_X = 2'd0;
  localparam logic [1:0] LOP_Y = 2'd1;
  localparam logic [1:0] LOP_W = 2'd2;

  // Reciprocal of the Bezier denominator, exact for every reachable sum.
  localparam int unsigned BZ_XW = COORD_W + CW;
  localparam int unsigned BZ_SH = COORD_W + 2 * CW;
  localparam int unsigned BZ_MW = COORD_W + CW + 1;
  localparam int unsigned BZ_PW = BZ_XW + BZ_MW;
  localparam logic [BZ_MW-1:0] BZ_RECIP =
    BZ_MW'(((64'd1 << BZ_SH) + 64'(S2) - 64'd1) / 64'(S2));

  // Reciprocal of the step count for the width interpolation.
  localparam int unsigned WL_XW = WID_W + STEP_W;
  localparam int unsigned WL_SH = WID_W + 2 * STEP_W;
  localparam int unsigned WL_MW = WID_W + STEP_W + 1;
  localparam int unsigned WL_PW = WL_XW + WL_MW;
  localparam logic [WL_MW-1:0] WL_RECIP =
    WL_MW'(((64'd1 << WL_SH) + 64'(CURVE_STEPS) - 64'd1) / 64'(CURVE_STEPS));

  pss_bstate_e        state_q, state_d;
  pss_ret_e           ret_q, ret_d;
  pss_job_t           job_q, job_d;
  logic [COORD_W-1:0] tail_x_q, tail_x_d, tail_y_q, tail_y_d;
  logic [WID_W-1:0]   tail_w_q, tail_w_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [OUTCNT_W-1:0] ecnt_q, ecnt_d;
  logic [COORD_W-1:0] bx_q, bx_d, by_q, by_d;
  logic [WID_W-1:0]   bw_q, bw_d;
  logic [STEP_W-1:0]  k_q, k_d;
  logic               ax_q, ax_d;
  logic [1:0]         sub_q, sub_d;
  logic [DIV_W-1:0]   acc_q, acc_d;
  logic [COORD_W-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [WID_W-1:0]   tgt_w_q, tgt_w_d;
  logic [COORD_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [WID_W-1:0]   sw_q, sw_d;
  logic [WID_W-1:0]   n_q, n_d, i_q, i_d;
  logic [1:0]         op_q, op_d;
  logic [COORD_W-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic [COORD_W-1:0] cand_x_q, cand_x_d, cand_y_q, cand_y_d;
  logic [WID_W-1:0]   cand_w_q, cand_w_d;
  logic               pend_v_q, pend_v_d;
  pss_out_t           pend_q, pend_d;
  logic               outv_q, outv_d;
  pss_out_t           out_q, out_d;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic [DVS_W-1:0]   div_divisor;

  logic [COORD_W-1:0] la, lb, l_diff, l_res;
  logic               l_ge;
  logic [STEP_W-1:0]  r;
  logic [CW-1:0]      coef;
  logic [COORD_W-1:0] bval;
  logic [DIV_W-1:0]   term;
  logic [BZ_PW-1:0]   bz_prod;
  logic [WL_PW-1:0]   wl_prod;
  logic [COORD_W-1:0] bez_res;
  logic [WID_W-1:0]   wl_step;
  logic               wl_ge;
  logic [WID_W-1:0]   wl_diff, dw, q_eff;
  logic               skip, out_free;

  pss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign bstat_o.idle         = (state_q == B_IDLE);
  assign bstat_o.stored_count = cnt_q;
  assign out_valid_o          = outv_q;
  assign out_data_o           = out_q;
  assign out_free             = !outv_q || !out_stall_i;

  // Operands of the linear interpolation in progress.
  always_comb begin
    unique case (op_q)
      LOP_X:   begin la = sx_q; lb = tgt_x_q; end
      LOP_Y:   begin la = sy_q; lb = tgt_y_q; end
      default: begin la = COORD_W'(sw_q); lb = COORD_W'(tgt_w_q); end
    endcase
    l_ge   = lb >= la;
    l_diff = l_ge ? lb - la : la - lb;
    l_res  = l_ge ? la + div_q[COORD_W-1:0] : la - div_q[COORD_W-1:0];
  end

  // One Bezier term per cycle: weight times control value.
  always_comb begin
    r = STEP_W'(CURVE_STEPS) - k_q;
    unique case (sub_q)
      2'd0:    begin coef = CW'(r) * CW'(r);           bval = ax_q ? by_q : bx_q; end
      2'd1:    begin coef = CW'(2) * CW'(k_q) * CW'(r); bval = ax_q ? job_q.cy : job_q.cx; end
      default: begin coef = CW'(k_q) * CW'(k_q);       bval = ax_q ? job_q.ty : job_q.tx; end
    endcase
    term    = DIV_W'(coef) * DIV_W'(bval);
    // The accumulated sum is divided by the squared step count through its reciprocal.
    bz_prod = BZ_PW'(acc_q[BZ_XW-1:0]) * BZ_PW'(BZ_RECIP);
    bez_res = sat_coord(48'(bz_prod[BZ_PW-1:BZ_SH]));
    // The width product is divided by the step count the same way.
    wl_prod = WL_PW'(acc_q[WL_XW-1:0]) * WL_PW'(WL_RECIP);
    wl_step = wl_prod[WL_SH+WID_W-1:WL_SH];
    wl_ge   = job_q.tw >= bw_q;
    wl_diff = wl_ge ? job_q.tw - bw_q : bw_q - job_q.tw;
    dw      = (tgt_w_q >= tail_w_q) ? tgt_w_q - tail_w_q : tail_w_q - tgt_w_q;
    q_eff   = (cfg_i.width_quantum == '0) ? WID_W'(1) : cfg_i.width_quantum;
    skip    = (ecnt_q >= OUTCNT_W'(MAX_OUT)) ||
              (cnt_q != '0 && cand_x_q == tail_x_q && cand_y_q == tail_y_q);
  end

  // Sequencer of the back part.
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    job_d    = job_q;
    tail_x_d = tail_x_q;
    tail_y_d = tail_y_q;
    tail_w_d = tail_w_q;
    cnt_d    = cnt_q;
    ecnt_d   = ecnt_q;
    bx_d     = bx_q;
    by_d     = by_q;
    bw_d     = bw_q;
    k_d      = k_q;
    ax_d     = ax_q;
    sub_d    = sub_q;
    acc_d    = acc_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    tgt_w_d  = tgt_w_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    sw_d     = sw_q;
    n_d      = n_q;
    i_d      = i_q;
    op_d     = op_q;
    res_x_d  = res_x_q;
    res_y_d  = res_y_q;
    cand_x_d = cand_x_q;
    cand_y_d = cand_y_q;
    cand_w_d = cand_w_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    outv_d   = outv_q && out_stall_i;
    out_d    = out_q;
    pop_o    = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DVS_W'(1);

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          ecnt_d  = '0;
          tgt_x_d = job_i.tx;
          tgt_y_d = job_i.ty;
          tgt_w_d = job_i.tw;
          unique case (job_i.kind)
            JOB_CLEAR: begin
              tail_x_d = '0;
              tail_y_d = '0;
              tail_w_d = '0;
              cnt_d    = '0;
            end
            JOB_ROOT: begin
              cand_x_d = job_i.tx;
              cand_y_d = job_i.ty;
              cand_w_d = job_i.tw;
              ret_d    = RET_FIN;
              state_d  = B_EMIT;
            end
            JOB_DIFF: state_d = B_D_START;
            default: begin
              bx_d    = tail_x_q;
              by_d    = tail_y_q;
              bw_d    = tail_w_q;
              k_d     = STEP_W'(1);
              ax_d    = 1'b0;
              sub_d   = 2'd0;
              acc_d   = '0;
              state_d = B_BEZ_ACC;
            end
          endcase
        end
      end
      B_BEZ_ACC: begin
        if (sub_q == 2'd2) begin
          acc_d   = acc_q + term + DIV_W'(S2 / 2);
          state_d = B_BEZ_DIV;
        end else begin
          acc_d = acc_q + term;
          sub_d = sub_q + 2'd1;
        end
      end
      B_BEZ_DIV: begin
        if (!ax_q) begin
          tgt_x_d = bez_res;
          ax_d    = 1'b1;
          sub_d   = 2'd0;
          acc_d   = '0;
          state_d = B_BEZ_ACC;
        end else begin
          tgt_y_d = bez_res;
          state_d = B_WL_MUL;
        end
      end
      B_WL_MUL: begin
        acc_d   = DIV_W'(wl_diff) * DIV_W'(k_q);
        state_d = B_WL_DIV;
      end
      B_WL_DIV: begin
        tgt_w_d = wl_ge ? bw_q + wl_step : bw_q - wl_step;
        state_d = B_D_START;
      end
      B_D_START: begin
        // Number of pieces from the width change against the quantum.
        sx_d         = tail_x_q;
        sy_d         = tail_y_q;
        sw_d         = tail_w_q;
        div_start    = 1'b1;
        div_dividend = DIV_W'(dw);
        div_divisor  = q_eff;
        state_d      = B_D_NDIV;
      end
      B_D_NDIV: begin
        if (div_done) begin
          n_d = div_q[WID_W-1:0] + WID_W'(1);
          i_d = WID_W'(1);
          if (div_q[WID_W-1:0] == '0) begin
            cand_x_d = tgt_x_q;
            cand_y_d = tgt_y_q;
            cand_w_d = tgt_w_q;
            ret_d    = RET_DIFF;
            state_d  = B_EMIT;
          end else begin
            op_d    = LOP_X;
            state_d = B_L_MUL;
          end
        end
      end
      B_L_MUL: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(l_diff) * DIV_W'(i_q);
        div_divisor  = n_q;
        state_d      = B_L_DIV;
      end
      B_L_DIV: begin
        if (div_done) begin
          unique case (op_q)
            LOP_X: begin
              res_x_d = l_res;
              op_d    = LOP_Y;
              state_d = B_L_MUL;
            end
            LOP_Y: begin
              res_y_d = l_res;
              op_d    = LOP_W;
              state_d = B_L_MUL;
            end
            default: begin
              cand_x_d = res_x_q;
              cand_y_d = res_y_q;
              cand_w_d = l_res[WID_W-1:0];
              ret_d    = RET_SUB;
              state_d  = B_EMIT;
            end
          endcase
        end
      end
      B_EMIT: begin
        // The previous point leaves as not last once a newer one exists.
        if (skip || !pend_v_q || out_free) begin
          if (!skip) begin
            if (pend_v_q) begin
              outv_d = 1'b1;
              out_d  = pend_q;
            end
            pend_v_d = 1'b1;
            pend_d   = '{out_x: cand_x_q, out_y: cand_y_q, out_width: cand_w_q,
                         last_of_run: 1'b0};
            tail_x_d = cand_x_q;
            tail_y_d = cand_y_q;
            tail_w_d = cand_w_q;
            if (cnt_q < CNT_W'(STORE_MAX)) cnt_d = cnt_q + CNT_W'(1);
            ecnt_d = ecnt_q + OUTCNT_W'(1);
          end
          unique case (ret_q)
            RET_SUB: begin
              i_d = i_q + WID_W'(1);
              if (i_q + WID_W'(1) == n_q) begin
                cand_x_d = tgt_x_q;
                cand_y_d = tgt_y_q;
                cand_w_d = tgt_w_q;
                ret_d    = RET_DIFF;
              end else begin
                op_d    = LOP_X;
                state_d = B_L_MUL;
              end
            end
            RET_DIFF: begin
              if (job_q.kind == JOB_CURVE && k_q != STEP_W'(CURVE_STEPS)) begin
                k_d     = k_q + STEP_W'(1);
                ax_d    = 1'b0;
                sub_d   = 2'd0;
                acc_d   = '0;
                state_d = B_BEZ_ACC;
              end else begin
                state_d = B_FLUSH;
              end
            end
            default: state_d = B_FLUSH;
          endcase
        end
      end
      B_FLUSH: begin
        if (!pend_v_q) begin
          state_d = B_IDLE;
        end else if (out_free) begin
          outv_d             = 1'b1;
          out_d              = pend_q;
          out_d.last_of_run  = 1'b1;
          pend_v_d           = 1'b0;
          state_d            = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Control state and stroke tail.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ret_q    <= RET_FIN;
      tail_x_q <= '0;
      tail_y_q <= '0;
      tail_w_q <= '0;
      cnt_q    <= '0;
      ecnt_q   <= '0;
      pend_v_q <= 1'b0;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      tail_x_q <= tail_x_d;
      tail_y_q <= tail_y_d;
      tail_w_q <= tail_w_d;
      cnt_q    <= cnt_d;
      ecnt_q   <= ecnt_d;
      pend_v_q <= pend_v_d;
      outv_q   <= outv_d;
    end
  end

  // Working registers and result payloads.
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    bw_q     <= bw_d;
    k_q      <= k_d;
    ax_q     <= ax_d;
    sub_q    <= sub_d;
    acc_q    <= acc_d;
    tgt_x_q  <= tgt_x_d;
    tgt_y_q  <= tgt_y_d;
    tgt_w_q  <= tgt_w_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    sw_q     <= sw_d;
    n_q      <= n_d;
    i_q      <= i_d;
    op_q     <= op_d;
    res_x_q  <= res_x_d;
    res_y_q  <= res_y_d;
    cand_x_q <= cand_x_d;
    cand_y_q <= cand_y_d;
    cand_w_q <= cand_w_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

endmodule

@@ src/pen_stroke_smoother_core.sv @@
// Top level of the pen stroke smoother: registers, front part, job queue and back part.
//
//   Channel  | Signals                                   | Direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid_i, in_stall_o, in_data_i         | in
//   result   | out_valid_o, out_stall_i, out_data_o      | out
//   config   | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in
//            | cfg_data_i                                |
//
// A kept sample passes through a 25-step square root and a 35-step division in the
// front part. In the back part a target point needs a piece count on the shared 35-step
// divider, a subdivided point three divider runs, and each curve step adds its Bezier
// point and width. One request is in the block at a time.
// Reset is asynchronous and active low and needs no clearing pass.
// A stall on the result side holds the back part; the input is stalled until it finishes.
module pen_stroke_smoother_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pss_pkg::pss_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pss_pkg::pss_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [15:0]                        cfg_data_i
);
  import pss_pkg::*;

  pss_cfg_t   cfg_q;
  pss_bstat_t bstat;
  pss_job_t   push_job, head_job;
  logic       push, pop, fifo_empty;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_interval_ms <= 16'd50;
      cfg_q.min_distance_px <= 8'd3;
      cfg_q.speed_cap       <= 16'd512;
      cfg_q.width_quantum   <= 11'd102;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN_INTERVAL: cfg_q.min_interval_ms <= cfg_data_i;
        CFG_MIN_DISTANCE: cfg_q.min_distance_px <= cfg_data_i[7:0];
        CFG_SPEED_CAP:    cfg_q.speed_cap       <= cfg_data_i;
        default:          cfg_q.width_quantum   <= cfg_data_i[WID_W-1:0];
      endcase
    end
  end

  pss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg_q),
    .bstat_i      (bstat),
    .fifo_empty_i (fifo_empty),
    .push_o       (push),
    .job_o        (push_job)
  );

  pss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .job_o   (head_job)
  );

  pss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (fifo_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .bstat_o     (bstat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/pss_checker.sv @@
// Port-level checker of the pen stroke smoother and its bind to the top level.
module pss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pss_pkg::pss_out_t out_data_o
);
  import pss_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A taken request is followed by a stall of the input.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in the cycle after a request");

  // While a run is still open, no new request is taken.
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> in_stall_o)
    else $error("request taken during an open run");

  // Widths never exceed one.
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_width <= W_ONE)
    else $error("width out of range");

endmodule

bind pen_stroke_smoother_core pss_checker u_pss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ tb/pss_stroke_checker.sv @@
// Checker for the pen stroke smoother: predicts stroke points and compares them.
`timescale 1ns / 100ps

module pss_stroke_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  pss_pkg::pss_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  pss_pkg::pss_out_t out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       points_due_o
);
  import pss_pkg::*;

  // Configuration copy.
  longint unsigned min_interval, min_distance, cap_reg, quantum_reg;
  // Stroke state copy.
  longint unsigned last_px, last_py, last_time, hist_width;
  longint unsigned tail_px, tail_py, tail_w, point_count;

  pss_out_t points_due[$];
  pss_out_t run_points[$];

  assign points_due_o = points_due.size();

  function automatic longint unsigned clip_coord(longint unsigned v);
    return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
  endfunction

  // Integer square root, rounded down.
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd4294967295;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Linear interpolation rounding toward the start value.
  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned i, longint unsigned n);
    if (b >= a) return a + (b - a) * i / n;
    return a - (a - b) * i / n;
  endfunction

  function automatic longint unsigned curve_pt(longint unsigned b, longint unsigned c,
                                               longint unsigned e, longint unsigned k);
    longint unsigned r, num;
    r = CURVE_STEPS - k;
    num = r * r * b + 2 * k * r * c + k * k * e;
    return clip_coord((num + 50) / 100);
  endfunction

  // Append one point unless full or a repeat of the tail.
  task automatic push_point(longint unsigned x, longint unsigned y, longint unsigned w);
    pss_out_t p;
    if (run_points.size() >= MAX_OUT) return;
    if (point_count > 0 && x == tail_px && y == tail_py) return;
    p.out_x = x[23:0];
    p.out_y = y[23:0];
    p.out_width = w[10:0];
    p.last_of_run = 1'b0;
    run_points.push_back(p);
    tail_px = x;
    tail_py = y;
    tail_w = w;
    if (point_count < STORE_MAX) point_count++;
  endtask

  // Step from the tail toward a target, splitting large width changes.
  task automatic split_toward(longint unsigned x, longint unsigned y, longint unsigned w);
    longint unsigned sx, sy, sw, q, dw, n;
    sx = tail_px;
    sy = tail_py;
    sw = tail_w;
    q = quantum_reg ? quantum_reg : 1;
    dw = (w >= sw) ? w - sw : sw - w;
    n = dw / q + 1;
    for (longint unsigned i = 1; i < n; i++)
      push_point(blend(sx, x, i, n), blend(sy, y, i, n), blend(sw, w, i, n));
    push_point(x, y, w);
  endtask

  function automatic longint unsigned speed_width(longint unsigned sq, longint unsigned dt);
    longint unsigned d8, cap, ratio, w, lim;
    d8 = int_root(sq << 16);
    cap = cap_reg ? cap_reg : 1;
    if (dt == 0) ratio = d8 ? 1024 : 0;
    else ratio = d8 * 1024 / (dt * cap);
    if (ratio > 1024) ratio = 1024;
    w = 1024 - ratio;
    if (w < W_FLOOR) w = W_FLOOR;
    lim = d8 * ((point_count > 4) ? STEP_LATE : STEP_EARLY) / 256;
    if (w > hist_width && w - hist_width > lim) w = hist_width + lim;
    else if (w < hist_width && hist_width - w > lim) w = hist_width - lim;
    return (w + hist_width) / 2;
  endfunction

  task automatic clear_stroke();
    last_px = 0; last_py = 0; last_time = 0; hist_width = 0;
    tail_px = 0; tail_py = 0; tail_w = 0; point_count = 0;
  endtask

  // Work out the points caused by one request.
  task automatic predict_request(pss_in_t req);
    longint unsigned px, py, t, dt, dx, dy, sq, w, bx, by, bw, cx, cy, ex, ey;
    px = req.pen_x;
    py = req.pen_y;
    t = req.time_ms;
    run_points.delete();
    if (req.func == FUNC_START) begin
      clear_stroke();
    end else if (req.func == FUNC_PEN_UP) begin
      if (point_count != 0)
        split_toward(clip_coord(px << FRAC_BITS), clip_coord(py << FRAC_BITS), W_LIFT);
    end else if (req.func == FUNC_SAMPLE) begin
      if (point_count == 0) begin
        push_point(px << FRAC_BITS, py << FRAC_BITS, W_ROOT);
        last_px = px; last_py = py; last_time = t; hist_width = W_ROOT;
      end else begin
        dt = (t - last_time) & 64'hFFFFFFFF;
        dx = (px >= last_px) ? px - last_px : last_px - px;
        dy = (py >= last_py) ? py - last_py : last_py - py;
        sq = dx * dx + dy * dy;
        if (!(dt < min_interval || sq < min_distance * min_distance)) begin
          w = speed_width(sq, dt);
          if (point_count == 1) begin
            split_toward(clip_coord(((last_px + px + 1) << FRAC_BITS) >> 1),
                         clip_coord(((last_py + py + 1) << FRAC_BITS) >> 1), w);
          end else begin
            bx = tail_px; by = tail_py; bw = tail_w;
            cx = last_px << FRAC_BITS;
            cy = last_py << FRAC_BITS;
            ex = ((last_px + px) << FRAC_BITS) >> 1;
            ey = ((last_py + py) << FRAC_BITS) >> 1;
            for (longint unsigned k = 1; k <= CURVE_STEPS; k++)
              split_toward(curve_pt(bx, cx, ex, k), curve_pt(by, cy, ey, k),
                           blend(bw, w, k, CURVE_STEPS));
          end
          last_px = px; last_py = py; last_time = t; hist_width = w;
        end
      end
    end
    if (run_points.size() > 0) run_points[$].last_of_run = 1'b1;
    foreach (run_points[i]) points_due.push_back(run_points[i]);
  endtask

  // Watch the three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    pss_out_t exp_pt;
    if (!rst_ni) begin
      min_interval = 50; min_distance = 3; cap_reg = 512; quantum_reg = 102;
      clear_stroke();
      points_due.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MIN_INTERVAL: min_interval = cfg_data_i;
          CFG_MIN_DISTANCE: min_distance = cfg_data_i[7:0];
          CFG_SPEED_CAP:    cap_reg = cfg_data_i;
          CFG_WIDTH_QUANT:  quantum_reg = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (points_due.size() == 0) begin
          if (fail_count_o < 10) $display("mismatch: unexpected point %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_pt = points_due.pop_front();
          if (exp_pt !== out_data_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %p actual %p", exp_pt, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_request(in_data_i);
    end
  end

endmodule

@@ tb/tb_pen_stroke_smoother_core.sv @@
// Testbench top for the pen stroke smoother: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps

module tb_pen_stroke_smoother_core;
  import pss_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pss_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pss_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MIN_INTERVAL;
  logic [15:0] cfg_data = '0;
  int unsigned fail_count, points_due;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;

  // Sample history used to make plausible strokes.
  int unsigned cur_x = 1000, cur_y = 1000;
  longint unsigned cur_t = 0;

  always #6 clk_i = ~clk_i;

  pen_stroke_smoother_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  pss_stroke_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .points_due_o(points_due)
  );

  // Random stall on the result side, except during a steady stretch.
  always @(negedge clk_i) begin
    out_stall <= !steady && ($urandom_range(99) < 12);
  end

  // Watchdog on cycles with no accepted transfer.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("FAIL pen_stroke_smoother_core");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Offer one request; valid stays high while stalled.
  task automatic send_request(logic [1:0] func, logic [15:0] x, logic [15:0] y,
                              logic [31:0] t);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 12) @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= '{func: func, pen_x: x, pen_y: y, time_ms: t};
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // Wait until every expected point has come and the block is idle, then let it settle.
  task automatic drain();
    while (points_due != 0 || in_stall) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Next sample of a plausible stroke, with occasional wild jumps.
  task automatic stroke_sample();
    int unsigned span;
    span = ($urandom_range(9) == 0) ? 400 : 20;
    cur_x = (cur_x + $urandom_range(2 * span) + 65536 - span) % 65536;
    cur_y = (cur_y + $urandom_range(2 * span) + 65536 - span) % 65536;
    cur_t = (cur_t + (($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(300) + 40))
            & 64'hFFFFFFFF;
    send_request(FUNC_SAMPLE, cur_x[15:0], cur_y[15:0], cur_t[31:0]);
  endtask

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) stroke_sample();
    else if (pick < 88) send_request(FUNC_PEN_UP, 16'($urandom), 16'($urandom), $urandom);
    else if (pick < 95) send_request(FUNC_START, 16'($urandom), 16'($urandom), $urandom);
    else if (pick < 98) send_request(FUNC_SAMPLE, 16'($urandom), 16'($urandom), $urandom);
    else send_request(FUNC_RSVD, 16'($urandom), 16'($urandom), $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes of the fields and every selector.
    send_request(FUNC_PEN_UP, 16'd5, 16'd5, 32'd0);
    send_request(FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0);
    send_request(FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 32'h0000_0100);
    send_request(FUNC_SAMPLE, 16'hFFF0, 16'hFFFF, 32'h0000_0110);
    send_request(FUNC_SAMPLE, 16'hFF00, 16'hFF00, 32'h0000_0200);
    send_request(FUNC_SAMPLE, 16'hFE00, 16'hFF80, 32'h0000_0300);
    send_request(FUNC_PEN_UP, 16'hFFFF, 16'h0000, 32'd0);
    send_request(FUNC_RSVD, 16'h1234, 16'h5678, 32'hDEAD_BEEF);
    send_request(FUNC_START, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(FUNC_SAMPLE, 16'd0, 16'd0, 32'd0);
    send_request(FUNC_SAMPLE, 16'd1, 16'd1, 32'd100);
    send_request(FUNC_SAMPLE, 16'd3000, 16'd0, 32'd101);
    send_request(FUNC_SAMPLE, 16'd3000, 16'd0, 32'd200);
    send_request(FUNC_SAMPLE, 16'd0, 16'd3000, 32'd210);
    send_request(FUNC_PEN_UP, 16'd0, 16'd0, 32'd0);
    send_request(FUNC_START, 16'd0, 16'd0, 32'd0);
    drain();

    // Extreme settings: no minimums, smallest cap and quantum, zero intervals allowed.
    write_reg(CFG_MIN_INTERVAL, 16'd0);
    write_reg(CFG_MIN_DISTANCE, 16'd0);
    write_reg(CFG_SPEED_CAP, 16'd0);
    write_reg(CFG_WIDTH_QUANT, 16'd0);
    send_request(FUNC_SAMPLE, 16'd100, 16'd100, 32'd7);
    send_request(FUNC_SAMPLE, 16'd100, 16'd100, 32'd7);
    send_request(FUNC_SAMPLE, 16'd140, 16'd100, 32'd7);
    send_request(FUNC_SAMPLE, 16'd160, 16'd130, 32'd9);
    send_request(FUNC_PEN_UP, 16'd170, 16'd130, 32'd0);
    send_request(FUNC_START, 16'd0, 16'd0, 32'd0);

    // Random phases under several settings.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(CFG_MIN_INTERVAL, 16'd50);  write_reg(CFG_MIN_DISTANCE, 16'd3);
          write_reg(CFG_SPEED_CAP, 16'd512);    write_reg(CFG_WIDTH_QUANT, 16'd102);
        end
        1: begin
          write_reg(CFG_MIN_INTERVAL, 16'hFFFF); write_reg(CFG_MIN_DISTANCE, 16'd255);
          write_reg(CFG_SPEED_CAP, 16'hFFFF);    write_reg(CFG_WIDTH_QUANT, 16'd1024);
        end
        2: begin
          write_reg(CFG_MIN_INTERVAL, 16'd10);  write_reg(CFG_MIN_DISTANCE, 16'd1);
          write_reg(CFG_SPEED_CAP, 16'd1);      write_reg(CFG_WIDTH_QUANT, 16'd1);
        end
        default: begin
          write_reg(CFG_MIN_INTERVAL, 16'd20);  write_reg(CFG_MIN_DISTANCE, 16'd2);
          write_reg(CFG_SPEED_CAP, 16'd200);    write_reg(CFG_WIDTH_QUANT, 16'd40);
        end
      endcase
      send_request(FUNC_START, 16'd0, 16'd0, 32'd0);
      steady = (phase == 3);
      for (int n = 0; n < 34; n++) random_request();
      steady = 1'b0;
    end

    drain();
    if (fail_count == 0) $display("PASS pen_stroke_smoother_core");
    else $display("FAIL pen_stroke_smoother_core");
    $finish;
  end

endmodule
